/* hdl/stsc_pkg.sv */
// ----------------------------------------------------------------------------
// stsc_pkg
// Types and constants shared by the sequential turn-signal controller.
// ----------------------------------------------------------------------------
package stsc_pkg;

  typedef struct packed {
    logic left_button;
    logic right_button;
    logic brake_button;
  } in_t;

  typedef struct packed {
    logic [7:0] lamps;
    logic       flash_step;
  } out_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_SWEEP_LAST    = 2'd0;
  localparam logic [1:0] REG_HAZARD_HALF   = 2'd1;
  localparam logic [1:0] REG_FLASH_DIVIDER = 2'd2;

  // Configuration reset values.
  localparam logic [1:0] SWEEP_LAST_RESET    = 2'd3;
  localparam logic [3:0] HAZARD_HALF_RESET   = 4'd4;
  localparam logic [3:0] FLASH_DIVIDER_RESET = 4'd4;

  localparam logic [7:0] LEFT_NIBBLE  = 8'b1111_0000;
  localparam logic [7:0] RIGHT_NIBBLE = 8'b0000_1111;
  localparam logic [7:0] ALL_LAMPS    = 8'hFF;

endpackage

/* hdl/sequential_turn_signal_controller.sv */
// ----------------------------------------------------------------------------
// sequential_turn_signal_controller
// Latches turn, hazard and brake modes from button levels and drives the
// eight tail lamps with outward sweeps, hazard blinking or solid brake light.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one word per tick with the left,
//     right and brake button levels.
//   out channel (out_valid/out_ready/out_data): one word per input word with
//     the lamp byte after that tick and a flag marking a lamp update step.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//     always ready; write only while no word is in flight.
//   The result is valid in the cycle after input acceptance. One word is
//   taken every cycle while the receiver keeps up; the single result register
//   sets that figure, and the input is ready whenever that register is empty
//   or is being drained. When the receiver stalls, the result holds and the
//   input stalls with it. Reset clears all modes, counters and lamps, empties
//   the result register and loads the register defaults (last position 3,
//   half period 4, divider 4).
// ----------------------------------------------------------------------------
module sequential_turn_signal_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  stsc_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output stsc_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [3:0]    cfg_data
);

  logic [1:0] sweep_last;
  logic [3:0] hazard_half;
  logic [3:0] flash_divider;

  logic [7:0] lamp_reg,      lamp_reg_next;
  logic [1:0] left_pos,      left_pos_next;
  logic [1:0] right_pos,     right_pos_next;
  logic [3:0] hazard_count,  hazard_count_next;
  logic       hazard_phase,  hazard_phase_next;
  logic       hazard_mode,   hazard_mode_next;
  logic       left_latched,  left_latched_next;
  logic       right_latched, right_latched_next;
  logic       brake_latched, brake_latched_next;
  logic       left_held,     left_held_next;
  logic       right_held,    right_held_next;
  logic       brake_held,    brake_held_next;
  logic [3:0] tick_count,    tick_count_next;
  logic       step;
  logic [4:0] tick_inc;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign tick_inc  = {1'b0, tick_count} + 5'd1;
  assign step      = tick_inc >= {1'b0, flash_divider};

  always_comb begin
    left_held_next     = left_held;
    right_held_next    = right_held;
    brake_held_next    = brake_held;
    hazard_mode_next   = hazard_mode;
    left_latched_next  = left_latched;
    right_latched_next = right_latched;
    brake_latched_next = brake_latched;

    // Button handling; left and right high together on a tick toggle hazard mode.
    if ((!left_held || !right_held) && in_data.left_button && in_data.right_button) begin
      hazard_mode_next = !hazard_mode;
      left_held_next   = 1'b1;
      right_held_next  = 1'b1;
      brake_held_next  = 1'b0;
    end else if (!hazard_mode) begin
      if (left_held && !in_data.left_button) begin
        left_held_next = 1'b0;
      end else if (!left_held && in_data.left_button) begin
        left_latched_next  = !left_latched;
        left_held_next     = 1'b1;
        right_latched_next = 1'b0;
      end
      if (right_held && !in_data.right_button) begin
        right_held_next = 1'b0;
      end else if (!right_held && in_data.right_button) begin
        right_latched_next = !right_latched_next;
        right_held_next    = 1'b1;
        left_latched_next  = 1'b0;
      end
      if (brake_held && !in_data.brake_button) begin
        brake_held_next = 1'b0;
      end else if (!brake_held && in_data.brake_button) begin
        brake_latched_next = !brake_latched;
        brake_held_next    = 1'b1;
      end
    end else begin
      if (left_held && !in_data.left_button) begin
        left_held_next = 1'b0;
      end
      if (right_held && !in_data.right_button) begin
        right_held_next = 1'b0;
      end
    end

    lamp_reg_next     = lamp_reg;
    left_pos_next     = left_pos;
    right_pos_next    = right_pos;
    hazard_count_next = hazard_count;
    hazard_phase_next = hazard_phase;
    tick_count_next   = tick_inc[3:0];

    if (step) begin
      tick_count_next = 4'd0;
      if (hazard_mode_next) begin
        lamp_reg_next = hazard_phase ? stsc_pkg::ALL_LAMPS : 8'h00;
        if (hazard_count < hazard_half) begin
          hazard_count_next = hazard_count + 4'd1;
        end else begin
          hazard_count_next = 4'd0;
          hazard_phase_next = !hazard_phase;
        end
      end else begin
        if (right_latched_next || right_pos != 2'd0) begin
          lamp_reg_next[3:0] = 4'b1000 >> right_pos;
          right_pos_next     = (right_pos < sweep_last) ? right_pos + 2'd1 : 2'd0;
        end else begin
          right_pos_next     = 2'd0;
          lamp_reg_next[3:0] = brake_latched_next ? stsc_pkg::RIGHT_NIBBLE[3:0] : 4'h0;
        end
        if (left_latched_next || left_pos != 2'd0) begin
          lamp_reg_next[7:4] = 4'b0001 << left_pos;
          left_pos_next      = (left_pos < sweep_last) ? left_pos + 2'd1 : 2'd0;
        end else begin
          left_pos_next      = 2'd0;
          lamp_reg_next[7:4] = brake_latched_next ? stsc_pkg::LEFT_NIBBLE[7:4] : 4'h0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_last    <= stsc_pkg::SWEEP_LAST_RESET;
      hazard_half   <= stsc_pkg::HAZARD_HALF_RESET;
      flash_divider <= stsc_pkg::FLASH_DIVIDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stsc_pkg::REG_SWEEP_LAST:    sweep_last    <= cfg_data[1:0];
        stsc_pkg::REG_HAZARD_HALF:   hazard_half   <= cfg_data;
        stsc_pkg::REG_FLASH_DIVIDER: flash_divider <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_reg      <= 8'h00;
      left_pos      <= 2'd0;
      right_pos     <= 2'd0;
      hazard_count  <= 4'd0;
      hazard_phase  <= 1'b0;
      hazard_mode   <= 1'b0;
      left_latched  <= 1'b0;
      right_latched <= 1'b0;
      brake_latched <= 1'b0;
      left_held     <= 1'b0;
      right_held    <= 1'b0;
      brake_held    <= 1'b0;
      tick_count    <= 4'd0;
    end else if (accept) begin
      lamp_reg      <= lamp_reg_next;
      left_pos      <= left_pos_next;
      right_pos     <= right_pos_next;
      hazard_count  <= hazard_count_next;
      hazard_phase  <= hazard_phase_next;
      hazard_mode   <= hazard_mode_next;
      left_latched  <= left_latched_next;
      right_latched <= right_latched_next;
      brake_latched <= brake_latched_next;
      left_held     <= left_held_next;
      right_held    <= right_held_next;
      brake_held    <= brake_held_next;
      tick_count    <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.lamps      <= lamp_reg_next;
      out_data.flash_step <= step;
    end
  end

endmodule
